FILE: sv/mcr_pkg.sv
// shared types, constants and helpers for the midpoint circle rasterizer
package mcr_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int CENTER_W    = 13;
    localparam int RADIUS_W    = 11;
    localparam int STEP_W      = 12;
    localparam int DEC_W       = 15;
    localparam int COLOR_W     = 24;
    localparam int DIM_W       = 13;
    localparam int PT_W        = CENTER_W + 1;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PT_CNT_W    = 3;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [PT_CNT_W-1:0] LAST_POINT = 3'd7;

    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [STEP_W-1:0]   x;
        logic [STEP_W-1:0]   y;
        logic [COLOR_W-1:0]  color;
        logic                done;
    } job_t;

    typedef struct packed {
        logic swap;
        logic neg_a;
        logic neg_b;
    } octant_t;

    // mirror order (x,y) (y,x) (-x,-y) (-y,-x) (-x,y) (x,-y) (-y,x) (y,-x)
    function automatic octant_t octant_sel(input logic [PT_CNT_W-1:0] idx);
        octant_t o;
        case (idx)
            3'd0:    o = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
            3'd1:    o = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b0};
            3'd2:    o = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b1};
            3'd3:    o = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b1};
            3'd4:    o = '{swap: 1'b0, neg_a: 1'b1, neg_b: 1'b0};
            3'd5:    o = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b1};
            3'd6:    o = '{swap: 1'b1, neg_a: 1'b1, neg_b: 1'b0};
            3'd7:    o = '{swap: 1'b1, neg_a: 1'b0, neg_b: 1'b1};
            default: o = '{swap: 1'b0, neg_a: 1'b0, neg_b: 1'b0};
        endcase
        return o;
    endfunction

endpackage

FILE: sv/mcr_if.sv
// request, pixel and configuration channel interfaces
interface mcr_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [mcr_pkg::CENTER_W-1:0]   center_x;
    logic [mcr_pkg::CENTER_W-1:0]   center_y;
    logic [mcr_pkg::RADIUS_W-1:0]   radius;
    logic [mcr_pkg::COLOR_W-1:0]    color;

    modport source (output valid, op, center_x, center_y, radius, color, input ready);
    modport sink   (input valid, op, center_x, center_y, radius, color, output ready);
endinterface

interface mcr_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mcr_pkg::COORD_WIDTH-1:0] pixel_x;
    logic [mcr_pkg::COORD_WIDTH-1:0] pixel_y;
    logic [mcr_pkg::COLOR_W-1:0]    pixel_color;
    logic                           write_enable;
    logic                           last;
    logic                           done_res;

    modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, last, done_res,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, write_enable, last, done_res,
                    output ready);
endinterface

interface mcr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mcr_pkg::CFG_IDX_W-1:0]   index;
    logic [mcr_pkg::DIM_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/mcr_front.sv
// front end: accepts requests, runs the midpoint decision step, queues octant jobs
module mcr_front (
    input  logic           clk,
    input  logic           rst_n,
    mcr_cmd_if.sink        cmd,
    output logic           job_valid,
    input  logic           job_ready,
    output mcr_pkg::job_t  job
);

    logic [mcr_pkg::CENTER_W-1:0] cx_reg, cx_next;
    logic [mcr_pkg::CENTER_W-1:0] cy_reg, cy_next;
    logic [mcr_pkg::STEP_W-1:0]   x_reg, x_next;
    logic [mcr_pkg::STEP_W-1:0]   y_reg, y_next;
    logic [mcr_pkg::DEC_W-1:0]    d_reg, d_next;
    logic [mcr_pkg::COLOR_W-1:0]  color_reg, color_next;
    logic                         active_reg, active_next;

    logic                         start;
    logic                         step;
    logic                         accept;
    logic [mcr_pkg::STEP_W-1:0]   x_b;
    logic [mcr_pkg::STEP_W-1:0]   y_b;
    logic [mcr_pkg::DEC_W-1:0]    d_b;
    logic [mcr_pkg::STEP_W:0]     y_dec;
    logic                         done;

    assign start     = (cmd.op == mcr_pkg::OP_START);
    assign step      = start || active_reg;
    assign cmd.ready = job_ready;
    assign accept    = cmd.valid && cmd.ready;
    assign job_valid = cmd.valid && step;

    always_comb
    begin
        cx_next    = start ? cmd.center_x : cx_reg;
        cy_next    = start ? cmd.center_y : cy_reg;
        color_next = start ? cmd.color : color_reg;
        x_b        = start ? '0 : x_reg;
        y_b        = start ? mcr_pkg::STEP_W'(cmd.radius) : y_reg;
        d_b        = start ? (mcr_pkg::DEC_W'(1) - mcr_pkg::DEC_W'(cmd.radius)) : d_reg;

        if (d_b[mcr_pkg::DEC_W-1])
        begin
            d_next = d_b + mcr_pkg::DEC_W'({x_b, 1'b0}) + mcr_pkg::DEC_W'(3);
            y_dec  = {1'b0, y_b};
        end
        else
        begin
            d_next = d_b + ((mcr_pkg::DEC_W'(x_b) - mcr_pkg::DEC_W'(y_b)) << 1)
                   + mcr_pkg::DEC_W'(5);
            y_dec  = {1'b0, y_b} - (mcr_pkg::STEP_W+1)'(1);
        end
        x_next = x_b + mcr_pkg::STEP_W'(1);
        y_next = y_dec[mcr_pkg::STEP_W-1:0];

        // a negative y means the octant has closed
        done        = y_dec[mcr_pkg::STEP_W] || (x_next > y_dec[mcr_pkg::STEP_W-1:0]);
        active_next = !done;

        job.cx    = cx_next;
        job.cy    = cy_next;
        job.x     = x_b;
        job.y     = y_b;
        job.color = color_next;
        job.done  = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end
        else if (accept && step)
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

endmodule

FILE: sv/mcr_queue.sv
// two-entry job queue between the front and back ends
module mcr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mcr_pkg::job_t  push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mcr_pkg::job_t  pop_data
);

    mcr_pkg::job_t               mem_reg [mcr_pkg::QUEUE_DEPTH];
    logic [mcr_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mcr_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mcr_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        push;
    logic                        pop;

    assign push_ready = (count_reg < mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mcr_pkg::QPTR_W'(mcr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + mcr_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mcr_pkg::QPTR_W'(mcr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + mcr_pkg::QPTR_W'(1);
        end
        count_next = count_reg + mcr_pkg::QCNT_W'(push) - mcr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/mcr_back.sv
// back end: mirrors each octant job into eight points, clips them, drives the pixel channel
module mcr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  mcr_pkg::job_t  job,
    mcr_pix_if.source      pix,
    mcr_cfg_if.sink        cfg
);

    mcr_pkg::job_t                  cur_reg;
    logic                           busy_reg;
    logic [mcr_pkg::PT_CNT_W-1:0]   idx_reg;
    logic [mcr_pkg::DIM_W-1:0]      width_reg;
    logic [mcr_pkg::DIM_W-1:0]      height_reg;

    logic                           out_valid_reg;
    logic [mcr_pkg::COORD_WIDTH-1:0] px_reg, px_next;
    logic [mcr_pkg::COORD_WIDTH-1:0] py_reg, py_next;
    logic [mcr_pkg::COLOR_W-1:0]    color_reg;
    logic                           we_reg, we_next;
    logic                           last_reg;
    logic                           done_reg;

    logic                           out_load;
    logic                           emit;
    logic                           take;
    mcr_pkg::octant_t               oct;
    logic [mcr_pkg::STEP_W-1:0]     a;
    logic [mcr_pkg::STEP_W-1:0]     b;
    logic [mcr_pkg::PT_W-1:0]       da;
    logic [mcr_pkg::PT_W-1:0]       db;
    logic [mcr_pkg::PT_W-1:0]       col;
    logic [mcr_pkg::PT_W-1:0]       row;
    logic                           col_in;
    logic                           row_in;

    assign out_load  = !out_valid_reg || pix.ready;
    assign emit      = busy_reg && out_load;
    assign take      = !busy_reg || (emit && (idx_reg == mcr_pkg::LAST_POINT));
    assign job_ready = take;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        oct = mcr_pkg::octant_sel(idx_reg);
        a   = oct.swap ? cur_reg.y : cur_reg.x;
        b   = oct.swap ? cur_reg.x : cur_reg.y;
        da  = oct.neg_a ? ('0 - mcr_pkg::PT_W'(a)) : mcr_pkg::PT_W'(a);
        db  = oct.neg_b ? ('0 - mcr_pkg::PT_W'(b)) : mcr_pkg::PT_W'(b);
        col = {cur_reg.cx[mcr_pkg::CENTER_W-1], cur_reg.cx} + da;
        row = {cur_reg.cy[mcr_pkg::CENTER_W-1], cur_reg.cy} + db;

        col_in = !col[mcr_pkg::PT_W-1]
              && (col[mcr_pkg::PT_W-2:0] < width_reg)
              && (32'(col[mcr_pkg::PT_W-2:0]) < (32'd1 << mcr_pkg::COORD_WIDTH));
        row_in = !row[mcr_pkg::PT_W-1]
              && (row[mcr_pkg::PT_W-2:0] < height_reg)
              && (32'(row[mcr_pkg::PT_W-2:0]) < (32'd1 << mcr_pkg::COORD_WIDTH));

        we_next = col_in && row_in;
        px_next = we_next ? mcr_pkg::COORD_WIDTH'(col[mcr_pkg::PT_W-2:0]) : '0;
        py_next = we_next ? mcr_pkg::COORD_WIDTH'(row[mcr_pkg::PT_W-2:0]) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            width_reg     <= mcr_pkg::WIDTH_RESET;
            height_reg    <= mcr_pkg::HEIGHT_RESET;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= job_valid;
            end
            if (emit)
            begin
                idx_reg <= idx_reg + mcr_pkg::PT_CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= emit;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    mcr_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                    mcr_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && job_valid)
        begin
            cur_reg <= job;
        end
        if (emit)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            color_reg <= cur_reg.color;
            we_reg    <= we_next;
            last_reg  <= (idx_reg == mcr_pkg::LAST_POINT);
            done_reg  <= cur_reg.done;
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_x      = px_reg;
    assign pix.pixel_y      = py_reg;
    assign pix.pixel_color  = color_reg;
    assign pix.write_enable = we_reg;
    assign pix.last         = last_reg;
    assign pix.done_res     = done_reg;

`ifndef SYNTHESIS
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (idx_reg == '0))
        else $error("last point held while point counter not wrapped");

    a_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (idx_reg != mcr_pkg::LAST_POINT)) |=> busy_reg)
        else $error("job dropped before all eight points were sent");

    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !we_reg) |-> ((px_reg == '0) && (py_reg == '0)))
        else $error("clipped point carries nonzero coordinates");
`endif

endmodule

FILE: sv/midpoint_circle_rasterizer.sv
// top level of the midpoint circle rasterizer
//
//  channel | dir | moves                                   | accepted when
//  cmd     | in  | start / advance request                 | cmd.valid && cmd.ready
//  pix     | out | one mirrored point per beat             | pix.valid && pix.ready
//  cfg     | in  | image width / height register write     | cfg.valid && cfg.ready
//
// each start or active advance request yields eight points, one per cycle while pix is ready,
// from the single point generator in the back end
// the front end takes a request every cycle while the two-entry job queue has room
// an advance with no circle running is taken and yields nothing
// reset clears all control state and sets the image to 640 x 480
// a stall on pix holds the point register, then the back end, then the queue and cmd
module midpoint_circle_rasterizer (
    input  logic      clk,
    input  logic      rst_n,
    mcr_cmd_if.sink   cmd,
    mcr_pix_if.source pix,
    mcr_cfg_if.sink   cfg
);

    logic           fq_valid;
    logic           fq_ready;
    mcr_pkg::job_t  fq_job;
    logic           qb_valid;
    logic           qb_ready;
    mcr_pkg::job_t  qb_job;

    mcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    mcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_job)
    );

    mcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .pix       (pix),
        .cfg       (cfg)
    );

endmodule

FILE: sim/circle_checker.sv
`timescale 1ns / 100ps
// checker that predicts the pixel stream of the midpoint circle rasterizer and compares it
module circle_checker (
    input  logic clk,
    input  logic rst_n,
    mcr_cmd_if   cmd,
    mcr_pix_if   pix,
    mcr_cfg_if   cfg,
    output int   errors,
    output int   pending,
    output logic live
);

    typedef struct packed {
        logic [mcr_pkg::COORD_WIDTH-1:0] col;
        logic [mcr_pkg::COORD_WIDTH-1:0] row;
        logic [mcr_pkg::COLOR_W-1:0]     color;
        logic                            wr;
        logic                            last;
        logic                            done;
    } pixel_t;

    pixel_t                              pixel_q[$];
    pixel_t                              want;
    logic [mcr_pkg::DIM_W-1:0]           img_w;
    logic [mcr_pkg::DIM_W-1:0]           img_h;
    logic signed [mcr_pkg::CENTER_W-1:0] ctr_col;
    logic signed [mcr_pkg::CENTER_W-1:0] ctr_row;
    logic [mcr_pkg::COLOR_W-1:0]         ink;
    int                                  step_x;
    int                                  step_y;
    int                                  decision;

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    function automatic void push_point(input int col, input int row, input logic fin,
                                       input logic finished);
        pixel_t p;
        int     lim;
        int     wl;
        int     hl;
        logic   in_img;
        lim = 1 << mcr_pkg::COORD_WIDTH;
        wl = int'(img_w);
        hl = int'(img_h);
        in_img = col >= 0 && row >= 0 && col < wl && row < hl && col < lim && row < lim;
        p.col = in_img ? col[mcr_pkg::COORD_WIDTH-1:0] : '0;
        p.row = in_img ? row[mcr_pkg::COORD_WIDTH-1:0] : '0;
        p.color = ink;
        p.wr = in_img;
        p.last = fin;
        p.done = finished;
        pixel_q.push_back(p);
    endfunction

    // one octant step: update the decision term, then queue the eight mirrored points
    function automatic void trace_step();
        int   x;
        int   y;
        int   cx;
        int   cy;
        logic fin;
        x = step_x;
        y = step_y;
        cx = int'(ctr_col);
        cy = int'(ctr_row);
        if (decision < 0)
            decision += 2 * x + 3;
        else
        begin
            decision += 2 * (x - y) + 5;
            step_y = y - 1;
        end
        step_x = x + 1;
        fin = !(step_x <= step_y);
        live = !fin;
        push_point(cx + x, cy + y, 1'b0, fin);
        push_point(cx + y, cy + x, 1'b0, fin);
        push_point(cx - x, cy - y, 1'b0, fin);
        push_point(cx - y, cy - x, 1'b0, fin);
        push_point(cx - x, cy + y, 1'b0, fin);
        push_point(cx + x, cy - y, 1'b0, fin);
        push_point(cx - y, cy + x, 1'b0, fin);
        push_point(cx + y, cy - x, 1'b1, fin);
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        live = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w = mcr_pkg::WIDTH_RESET;
            img_h = mcr_pkg::HEIGHT_RESET;
            ctr_col = '0;
            ctr_row = '0;
            ink = '0;
            step_x = 0;
            step_y = 0;
            decision = 0;
            live = 1'b0;
            pixel_q.delete();
            pending = 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("pixel with nothing expected: x %0d y %0d", pix.pixel_x, pix.pixel_y);
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    check_field("pixel_x", int'(want.col), int'(pix.pixel_x));
                    check_field("pixel_y", int'(want.row), int'(pix.pixel_y));
                    check_field("pixel_color", int'(want.color), int'(pix.pixel_color));
                    check_field("write_enable", int'(want.wr), int'(pix.write_enable));
                    check_field("last", int'(want.last), int'(pix.last));
                    check_field("done_res", int'(want.done), int'(pix.done_res));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == mcr_pkg::REG_IMAGE_WIDTH)
                    img_w = cfg.data;
                else if (cfg.index == mcr_pkg::REG_IMAGE_HEIGHT)
                    img_h = cfg.data;
            end
            if (cmd.valid && cmd.ready)
            begin
                if (cmd.op == mcr_pkg::OP_START)
                begin
                    ctr_col = $signed(cmd.center_x);
                    ctr_row = $signed(cmd.center_y);
                    ink = cmd.color;
                    step_x = 0;
                    step_y = int'(cmd.radius);
                    decision = 1 - step_y;
                    trace_step();
                end
                else if (live)
                    trace_step();
            end
            pending = pixel_q.size();
        end
    end
endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// top of the circle rasterizer testbench: clock, reset, request and register stimulus, verdict
module testbench;

    localparam int LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_took;
    logic cfg_took;
    logic steady;
    logic live;
    int   cycles;
    int   counted;
    int   cur_w;
    int   cur_h;
    int   errors;
    int   pending;

    mcr_cmd_if cmd_ch ();
    mcr_pix_if pix_ch ();
    mcr_cfg_if cfg_ch ();

    midpoint_circle_rasterizer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    circle_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .pix     (pix_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending),
        .live    (live)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cmd_took <= cmd_ch.valid && cmd_ch.ready;
        cfg_took <= cfg_ch.valid && cfg_ch.ready;
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        pix_ch.ready <= steady || ($urandom_range(99) >= 33);

    task automatic send_request(input logic op, input logic [mcr_pkg::CENTER_W-1:0] cx,
                                input logic [mcr_pkg::CENTER_W-1:0] cy,
                                input logic [mcr_pkg::RADIUS_W-1:0] r,
                                input logic [mcr_pkg::COLOR_W-1:0] color);
        int gap;
        if (op == mcr_pkg::OP_START || live)
            counted++;
        gap = (!steady && $urandom_range(99) < 33) ? int'($urandom_range(4, 1)) : 0;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.op <= op;
        cmd_ch.center_x <= cx;
        cmd_ch.center_y <= cy;
        cmd_ch.radius <= r;
        cmd_ch.color <= color;
        cmd_ch.valid <= 1'b1;
        do @(negedge clk); while (!cmd_took);
    endtask

    task automatic advance();
        send_request(mcr_pkg::OP_ADVANCE, mcr_pkg::CENTER_W'($urandom),
                     mcr_pkg::CENTER_W'($urandom), mcr_pkg::RADIUS_W'($urandom),
                     mcr_pkg::COLOR_W'($urandom));
    endtask

    // drain every expected pixel, then let any ignored request clear the pipeline
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_image(input int w, input int h);
        cfg_ch.index <= mcr_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data <= mcr_pkg::DIM_W'(w);
        cfg_ch.valid <= 1'b1;
        do @(negedge clk); while (!cfg_took);
        cfg_ch.index <= mcr_pkg::REG_IMAGE_HEIGHT;
        cfg_ch.data <= mcr_pkg::DIM_W'(h);
        do @(negedge clk); while (!cfg_took);
        cfg_ch.valid <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    function automatic logic [mcr_pkg::CENTER_W-1:0] pick_center(input int span);
        int hi;
        hi = (span + 80 > 4135) ? 4135 : span + 80;
        if ($urandom_range(9) < 3)
            return mcr_pkg::CENTER_W'($urandom);
        return mcr_pkg::CENTER_W'(int'($urandom_range(hi, 0)) - 40);
    endfunction

    function automatic logic [mcr_pkg::RADIUS_W-1:0] pick_radius();
        int k;
        k = int'($urandom_range(99));
        if (k < 70)
            return mcr_pkg::RADIUS_W'($urandom_range(12, 0));
        if (k < 90)
            return mcr_pkg::RADIUS_W'($urandom_range(48, 13));
        return mcr_pkg::RADIUS_W'($urandom_range(2047, 49));
    endfunction

    // mostly whole circles, some cut short by a new start, some stray advances
    task automatic random_burst();
        int                           pick;
        int                           steps;
        logic [mcr_pkg::RADIUS_W-1:0] r;
        pick = int'($urandom_range(99));
        if (pick < 88)
        begin
            r = pick_radius();
            send_request(mcr_pkg::OP_START, pick_center(cur_w), pick_center(cur_h), r,
                         mcr_pkg::COLOR_W'($urandom));
            steps = (r > 48 || $urandom_range(4) == 0) ? int'($urandom_range(8, 0)) : 4096;
            while (live && steps > 0)
            begin
                advance();
                steps--;
            end
        end
        else
            advance();
    endtask

    initial
    begin : stimulus
        int target;
        int quota;
        int w;
        int h;
        rst_n = 1'b0;
        cycles = 0;
        counted = 0;
        steady = 1'b0;
        cmd_took = 1'b0;
        cfg_took = 1'b0;
        cur_w = int'(mcr_pkg::WIDTH_RESET);
        cur_h = int'(mcr_pkg::HEIGHT_RESET);
        cmd_ch.valid = 1'b0;
        cmd_ch.op = mcr_pkg::OP_START;
        cmd_ch.center_x = '0;
        cmd_ch.center_y = '0;
        cmd_ch.radius = '0;
        cmd_ch.color = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = mcr_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data = '0;
        pix_ch.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // advance with no circle, zero radius, a full small circle, far corners
        send_request(mcr_pkg::OP_ADVANCE, 13'h1FFF, 13'h1FFF, 11'h7FF, 24'hFFFFFF);
        send_request(mcr_pkg::OP_START, 13'd10, 13'd10, 11'd0, 24'hFFFFFF);
        advance();
        send_request(mcr_pkg::OP_START, 13'd100, 13'd100, 11'd5, 24'h000000);
        repeat (4) advance();
        send_request(mcr_pkg::OP_START, 13'h1000, 13'h1000, 11'd2047, 24'hAAAAAA);
        advance();
        send_request(mcr_pkg::OP_START, 13'd4095, 13'd4095, 11'd2047, 24'h555555);
        advance();
        // a start while a circle is running
        send_request(mcr_pkg::OP_START, 13'd320, 13'd240, 11'd100, 24'h123456);
        advance();
        send_request(mcr_pkg::OP_START, 13'd0, 13'd0, 11'd3, 24'hABCDEF);
        repeat (3) advance();
        // circles touching the image border
        send_request(mcr_pkg::OP_START, 13'd639, 13'd479, 11'd1, 24'h00FF00);
        send_request(mcr_pkg::OP_START, 13'd638, 13'd1, 11'd2, 24'h0000FF);
        repeat (2) advance();

        counted = 0;
        target = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    w = 4096;
                    h = 4096;
                    quota = 40;
                end
                1:
                begin
                    w = 8191;
                    h = 8191;
                    quota = 30;
                end
                2:
                begin
                    w = 0;
                    h = 0;
                    quota = 10;
                end
                3:
                begin
                    w = 1;
                    h = 4096;
                    quota = 30;
                end
                4:
                begin
                    w = 4096;
                    h = 1;
                    quota = 30;
                end
                5:
                begin
                    w = int'($urandom_range(4096, 1));
                    h = int'($urandom_range(4096, 1));
                    quota = 40;
                end
                6:
                begin
                    w = 640;
                    h = 480;
                    quota = 40;
                end
                default:
                begin
                    w = 1;
                    h = 1;
                    quota = 30;
                end
            endcase
            settle();
            set_image(w, h);
            steady = (ph == 0);
            target += quota;
            while (counted < target)
                random_burst();
        end
        steady = 1'b0;

        settle();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

FILE: files.f
sv/mcr_pkg.sv
sv/mcr_if.sv
sv/mcr_front.sv
sv/mcr_queue.sv
sv/mcr_back.sv
sv/midpoint_circle_rasterizer.sv
sim/circle_checker.sv
sim/testbench.sv
